/* hw/rtl/source_text_tokenizer_core_macros.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define STT_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define STT_NEVER(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define STT_ASSERT(name, prop)
`define STT_NEVER(name, expr)
`endif
`endif

/* hw/rtl/stt_pkg.sv */
`timescale 1ns / 1ps
package stt_pkg;

    localparam int MAX_SOURCE_BYTES = 65536;
    localparam int KW_CHARS = 6;
    localparam int KW_BITS = 8 * KW_CHARS;
    localparam int KW_IDX_W = $clog2(KW_CHARS);
    localparam int KW_COUNT = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int POS_CAP_I = (MAX_SOURCE_BYTES - 1 < 65535) ? MAX_SOURCE_BYTES - 1 : 65535;
    localparam logic [15:0] POS_CAP = POS_CAP_I[15:0];
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // token kinds
    localparam logic [5:0] K_NUMBER = 6'd0;
    localparam logic [5:0] K_STRING = 6'd1;
    localparam logic [5:0] K_IDENT = 6'd2;
    localparam logic [5:0] K_LABEL = 6'd3;
    localparam logic [5:0] K_KW0 = 6'd4;
    localparam logic [5:0] K_PLUS = 6'd21;
    localparam logic [5:0] K_MINUS = 6'd22;
    localparam logic [5:0] K_ARROW = 6'd23;
    localparam logic [5:0] K_STAR = 6'd24;
    localparam logic [5:0] K_SLASH = 6'd25;
    localparam logic [5:0] K_CARET = 6'd26;
    localparam logic [5:0] K_PERCENT = 6'd27;
    localparam logic [5:0] K_SEMI = 6'd28;
    localparam logic [5:0] K_COLON = 6'd29;
    localparam logic [5:0] K_COMMA = 6'd30;
    localparam logic [5:0] K_DOT = 6'd31;
    localparam logic [5:0] K_LBRACE = 6'd32;
    localparam logic [5:0] K_RBRACE = 6'd33;
    localparam logic [5:0] K_LPAREN = 6'd34;
    localparam logic [5:0] K_RPAREN = 6'd35;
    localparam logic [5:0] K_LBRACKET = 6'd36;
    localparam logic [5:0] K_RBRACKET = 6'd37;
    localparam logic [5:0] K_ASSIGN = 6'd38;
    localparam logic [5:0] K_EQUAL = 6'd39;
    localparam logic [5:0] K_NOTEQ = 6'd40;
    localparam logic [5:0] K_LESS = 6'd41;
    localparam logic [5:0] K_LESSEQ = 6'd42;
    localparam logic [5:0] K_GREATER = 6'd43;
    localparam logic [5:0] K_GREATEREQ = 6'd44;
    localparam logic [5:0] K_NEWLINE = 6'd45;
    localparam logic [5:0] K_EOF = 6'd46;
    localparam logic [5:0] K_ERROR = 6'd47;

    // error codes
    localparam logic [2:0] E_NONE = 3'd0;
    localparam logic [2:0] E_OPEN_COMMENT = 3'd1;
    localparam logic [2:0] E_OPEN_STRING = 3'd2;
    localparam logic [2:0] E_EMPTY_LABEL = 3'd3;
    localparam logic [2:0] E_LONE_BANG = 3'd4;
    localparam logic [2:0] E_UNKNOWN = 3'd5;

    // characters
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [3:0] {
        M_IDLE, M_LINECOM, M_BLOCK, M_BLOCKSTAR, M_SLASH, M_NUMBER, M_STRING,
        M_STRESC, M_LABEL, M_IDENT, M_MINUS, M_EQ, M_BANG, M_LT, M_GT, M_ERROR
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [2:0]  err;
        logic [15:0] line;
        logic [15:0] start;
        logic [15:0] len;
    } res_t;

    // one queue entry: the results of one input item
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } pair_t;

    // effect of a byte seen in idle mode
    typedef struct packed {
        mode_t       mode;
        logic        emit;
        logic [5:0]  kind;
        logic [2:0]  err;
        logic [15:0] len;
        logic        line_inc;
        logic        begin_tok;
        logic        ident;
    } idle_t;

    // keyword text, right-aligned, first character in the highest used byte
    localparam logic [KW_BITS-1:0] KW_STR [KW_COUNT] = '{
        KW_BITS'("if"), KW_BITS'("then"), KW_BITS'("else"), KW_BITS'("end"),
        KW_BITS'("while"), KW_BITS'("do"), KW_BITS'("repeat"), KW_BITS'("times"),
        KW_BITS'("print"), KW_BITS'("true"), KW_BITS'("false"), KW_BITS'("and"),
        KW_BITS'("or"), KW_BITS'("not"), KW_BITS'("start"), KW_BITS'("goto"),
        KW_BITS'("stop")
    };
    localparam logic [15:0] KW_LEN [KW_COUNT] = '{
        16'd2, 16'd4, 16'd4, 16'd3, 16'd5, 16'd2, 16'd6, 16'd5, 16'd5,
        16'd4, 16'd5, 16'd3, 16'd2, 16'd3, 16'd5, 16'd4, 16'd4
    };

    function automatic res_t mk_res(input logic [5:0] kind, input logic [2:0] err,
                                    input logic [15:0] start, input logic [15:0] len);
        res_t r;
        r.kind = kind;
        r.err = err;
        r.line = '0;
        r.start = start;
        r.len = len;
        return r;
    endfunction

    // keyword text with the first character in the low byte
    function automatic logic [KW_BITS-1:0] kw_le(input int k);
        logic [KW_BITS-1:0] w;
        w = '0;
        for (int i = 0; i < KW_CHARS; i++)
        begin
            if (i < int'(KW_LEN[k]))
            begin
                w[8*i +: 8] = KW_STR[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8];
            end
        end
        return w;
    endfunction

    // bytes past the word length are zero in the buffer
    function automatic logic [5:0] kw_kind(input logic [KW_BITS-1:0] wbuf,
                                           input logic [15:0] wlen);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (wlen == KW_LEN[i] && wbuf == kw_le(i))
            begin
                k = K_KW0 + 6'(i);
            end
        end
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == CH_UNDER;
    endfunction

    function automatic idle_t idle_fn(input logic [7:0] c);
        idle_t r;
        r = '0;
        r.mode = M_IDLE;
        case (c)
            CH_SP, CH_TAB, CH_CR: ;
            CH_LF:
            begin
                r.emit = 1'b1;
                r.kind = K_NEWLINE;
                r.len = 16'd1;
                r.line_inc = 1'b1;
            end
            CH_HASH: r.mode = M_LINECOM;
            CH_SLASH: begin r.mode = M_SLASH; r.begin_tok = 1'b1; end
            CH_QUOTE: begin r.mode = M_STRING; r.begin_tok = 1'b1; end
            CH_AT: begin r.mode = M_LABEL; r.begin_tok = 1'b1; end
            CH_MINUS: begin r.mode = M_MINUS; r.begin_tok = 1'b1; end
            CH_EQ: begin r.mode = M_EQ; r.begin_tok = 1'b1; end
            CH_BANG: begin r.mode = M_BANG; r.begin_tok = 1'b1; end
            CH_LT: begin r.mode = M_LT; r.begin_tok = 1'b1; end
            CH_GT: begin r.mode = M_GT; r.begin_tok = 1'b1; end
            CH_PLUS, CH_STAR, CH_CARET, CH_PERCENT, CH_SEMI, CH_COLON, CH_COMMA,
            CH_DOT, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACKET,
            CH_RBRACKET:
            begin
                r.emit = 1'b1;
                r.len = 16'd1;
                case (c)
                    CH_PLUS: r.kind = K_PLUS;
                    CH_STAR: r.kind = K_STAR;
                    CH_CARET: r.kind = K_CARET;
                    CH_PERCENT: r.kind = K_PERCENT;
                    CH_SEMI: r.kind = K_SEMI;
                    CH_COLON: r.kind = K_COLON;
                    CH_COMMA: r.kind = K_COMMA;
                    CH_DOT: r.kind = K_DOT;
                    CH_LBRACE: r.kind = K_LBRACE;
                    CH_RBRACE: r.kind = K_RBRACE;
                    CH_LPAREN: r.kind = K_LPAREN;
                    CH_RPAREN: r.kind = K_RPAREN;
                    CH_LBRACKET: r.kind = K_LBRACKET;
                    default: r.kind = K_RBRACKET;
                endcase
            end
            default:
            begin
                if (is_digit(c))
                begin
                    r.mode = M_NUMBER;
                    r.begin_tok = 1'b1;
                end
                else if (is_alpha(c) || c == CH_UNDER)
                begin
                    r.mode = M_IDENT;
                    r.begin_tok = 1'b1;
                    r.ident = 1'b1;
                end
                else
                begin
                    r.mode = M_ERROR;
                    r.emit = 1'b1;
                    r.kind = K_ERROR;
                    r.err = E_UNKNOWN;
                end
            end
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/stt_front.sv */
`timescale 1ns / 1ps
module stt_front
    import stt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  ch,
    input  logic        end_mark,
    output logic        push,
    output pair_t       entry
);

    mode_t              mode_reg, mode_next;
    logic [15:0]        line_reg, line_next;
    logic [15:0]        pos_reg, pos_next;
    logic [15:0]        start_reg, start_next;
    logic [KW_BITS-1:0] wbuf_reg, wbuf_next;
    logic [15:0]        wlen_reg, wlen_next;

    idle_t              id;
    logic               first_v, sec_v, call_idle, line_inc, failed;
    res_t               first, sec;
    logic [15:0]        wlen_grow;
    logic [KW_IDX_W-1:0] widx;

    assign id = idle_fn(ch);
    assign wlen_grow = (wlen_reg < CNT_MAX) ? wlen_reg + 16'd1 : wlen_reg;
    assign widx = wlen_reg[KW_IDX_W-1:0];

    // scanner: results of this byte and next scan state
    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        pos_next = pos_reg;
        start_next = start_reg;
        wbuf_next = wbuf_reg;
        wlen_next = wlen_reg;
        first_v = 1'b0;
        first = '0;
        sec_v = 1'b0;
        sec = '0;
        call_idle = 1'b0;
        line_inc = 1'b0;
        failed = 1'b0;
        if (end_mark)
        begin
            // flush pending token or error, then EOF unless the scan is in or ends in error
            case (mode_reg)
                M_BLOCK, M_BLOCKSTAR:
                begin
                    failed = 1'b1;
                    first = mk_res(K_ERROR, E_OPEN_COMMENT, start_reg, 16'd0);
                end
                M_STRING, M_STRESC:
                begin
                    failed = 1'b1;
                    first = mk_res(K_ERROR, E_OPEN_STRING, start_reg, 16'd0);
                end
                M_BANG:
                begin
                    failed = 1'b1;
                    first = mk_res(K_ERROR, E_LONE_BANG, start_reg, 16'd0);
                end
                M_LABEL:
                begin
                    if (wlen_reg <= 16'd1)
                    begin
                        failed = 1'b1;
                        first = mk_res(K_ERROR, E_EMPTY_LABEL, start_reg, 16'd0);
                    end
                    else
                    begin
                        first = mk_res(K_LABEL, E_NONE, start_reg, wlen_reg);
                    end
                end
                M_NUMBER: first = mk_res(K_NUMBER, E_NONE, start_reg, wlen_reg);
                M_IDENT: first = mk_res(kw_kind(wbuf_reg, wlen_reg), E_NONE, start_reg, wlen_reg);
                M_SLASH: first = mk_res(K_SLASH, E_NONE, start_reg, 16'd1);
                M_MINUS: first = mk_res(K_MINUS, E_NONE, start_reg, 16'd1);
                M_EQ: first = mk_res(K_ASSIGN, E_NONE, start_reg, 16'd1);
                M_LT: first = mk_res(K_LESS, E_NONE, start_reg, 16'd1);
                M_GT: first = mk_res(K_GREATER, E_NONE, start_reg, 16'd1);
                default: ;
            endcase
            first_v = (mode_reg != M_ERROR) && (mode_reg != M_IDLE) &&
                      (mode_reg != M_LINECOM);
            if (mode_reg != M_ERROR && !failed)
            begin
                sec_v = 1'b1;
                sec = mk_res(K_EOF, E_NONE, pos_reg, 16'd0);
            end
            mode_next = M_IDLE;
            line_next = 16'd1;
            pos_next = '0;
            start_next = '0;
            wbuf_next = '0;
            wlen_next = '0;
        end
        else
        begin
            case (mode_reg)
                M_ERROR: ;
                M_LINECOM: call_idle = (ch == CH_LF);
                M_BLOCK:
                begin
                    if (ch == CH_LF) line_inc = 1'b1;
                    else if (ch == CH_STAR) mode_next = M_BLOCKSTAR;
                end
                M_BLOCKSTAR:
                begin
                    if (ch == CH_SLASH) mode_next = M_IDLE;
                    else if (ch == CH_LF)
                    begin
                        line_inc = 1'b1;
                        mode_next = M_BLOCK;
                    end
                    else if (ch != CH_STAR) mode_next = M_BLOCK;
                end
                M_SLASH:
                begin
                    if (ch == CH_SLASH) mode_next = M_LINECOM;
                    else if (ch == CH_STAR) mode_next = M_BLOCK;
                    else
                    begin
                        first_v = 1'b1;
                        first = mk_res(K_SLASH, E_NONE, start_reg, 16'd1);
                        call_idle = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(ch) || ch == CH_DOT) wlen_next = wlen_grow;
                    else
                    begin
                        first_v = 1'b1;
                        first = mk_res(K_NUMBER, E_NONE, start_reg, wlen_reg);
                        call_idle = 1'b1;
                    end
                end
                M_STRING:
                begin
                    wlen_next = wlen_grow;
                    if (ch == CH_BSLASH) mode_next = M_STRESC;
                    else if (ch == CH_QUOTE)
                    begin
                        first_v = 1'b1;
                        first = mk_res(K_STRING, E_NONE, start_reg, wlen_grow);
                        mode_next = M_IDLE;
                    end
                end
                M_STRESC:
                begin
                    wlen_next = wlen_grow;
                    mode_next = M_STRING;
                end
                M_LABEL:
                begin
                    if (is_word(ch)) wlen_next = wlen_grow;
                    else if (wlen_reg <= 16'd1)
                    begin
                        first_v = 1'b1;
                        first = mk_res(K_ERROR, E_EMPTY_LABEL, start_reg, 16'd0);
                        mode_next = M_ERROR;
                    end
                    else
                    begin
                        first_v = 1'b1;
                        first = mk_res(K_LABEL, E_NONE, start_reg, wlen_reg);
                        call_idle = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_word(ch))
                    begin
                        if (wlen_reg < 16'(KW_CHARS)) wbuf_next[8*widx +: 8] = ch;
                        wlen_next = wlen_grow;
                    end
                    else
                    begin
                        first_v = 1'b1;
                        first = mk_res(kw_kind(wbuf_reg, wlen_reg), E_NONE, start_reg,
                                       wlen_reg);
                        call_idle = 1'b1;
                    end
                end
                M_MINUS, M_EQ, M_LT, M_GT:
                begin
                    first_v = 1'b1;
                    if ((mode_reg == M_MINUS && ch == CH_GT) ||
                        (mode_reg != M_MINUS && ch == CH_EQ))
                    begin
                        case (mode_reg)
                            M_MINUS: first = mk_res(K_ARROW, E_NONE, start_reg, 16'd2);
                            M_EQ: first = mk_res(K_EQUAL, E_NONE, start_reg, 16'd2);
                            M_LT: first = mk_res(K_LESSEQ, E_NONE, start_reg, 16'd2);
                            default: first = mk_res(K_GREATEREQ, E_NONE, start_reg, 16'd2);
                        endcase
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        case (mode_reg)
                            M_MINUS: first = mk_res(K_MINUS, E_NONE, start_reg, 16'd1);
                            M_EQ: first = mk_res(K_ASSIGN, E_NONE, start_reg, 16'd1);
                            M_LT: first = mk_res(K_LESS, E_NONE, start_reg, 16'd1);
                            default: first = mk_res(K_GREATER, E_NONE, start_reg, 16'd1);
                        endcase
                        call_idle = 1'b1;
                    end
                end
                M_BANG:
                begin
                    first_v = 1'b1;
                    if (ch == CH_EQ)
                    begin
                        first = mk_res(K_NOTEQ, E_NONE, start_reg, 16'd2);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        first = mk_res(K_ERROR, E_LONE_BANG, start_reg, 16'd0);
                        mode_next = M_ERROR;
                    end
                end
                default: call_idle = 1'b1;
            endcase
            // byte seen as if idle
            if (call_idle)
            begin
                mode_next = id.mode;
                line_inc = id.line_inc;
                sec_v = id.emit;
                sec = mk_res(id.kind, id.err, pos_reg, id.len);
                if (id.begin_tok)
                begin
                    start_next = pos_reg;
                    wlen_next = 16'd1;
                end
                if (id.ident)
                begin
                    wbuf_next = KW_BITS'(ch);
                end
            end
            if (line_inc && line_reg < CNT_MAX) line_next = line_reg + 16'd1;
            if (pos_reg < POS_CAP) pos_next = pos_reg + 16'd1;
        end
    end

    // pack results for the queue
    always_comb
    begin
        entry.two = first_v && sec_v;
        entry.r0 = first_v ? first : sec;
        entry.r1 = sec;
        entry.r0.line = line_reg;
        entry.r1.line = line_reg;
        push = take && (first_v || sec_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            line_reg <= 16'd1;
            pos_reg <= '0;
            start_reg <= '0;
            wbuf_reg <= '0;
            wlen_reg <= '0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            pos_reg <= pos_next;
            start_reg <= start_next;
            wbuf_reg <= wbuf_next;
            wlen_reg <= wlen_next;
        end
    end

endmodule

/* hw/rtl/stt_fifo.sv */
`timescale 1ns / 1ps
`include "source_text_tokenizer_core_macros.svh"
module stt_fifo
    import stt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  pair_t wdata,
    output logic  full,
    input  logic  pop,
    output logic  nonempty,
    output pair_t rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pair_t           slot_reg [DEPTH];
    logic [PW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full = (cnt_reg == CW'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign rdata = slot_reg[rp_reg];

    // pointer and count update
    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (pop)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        if (push && !pop) cnt_next = cnt_reg + CW'(1);
        else if (pop && !push) cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wp_reg] <= wdata;
    end

    `STT_NEVER(a_no_overflow, push && full)
    `STT_NEVER(a_no_underflow, pop && !nonempty)
    `STT_NEVER(a_count_range, cnt_reg > CW'(DEPTH))

endmodule

/* hw/rtl/stt_back.sv */
`timescale 1ns / 1ps
`include "source_text_tokenizer_core_macros.svh"
module stt_back
    import stt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  nonempty,
    input  pair_t rdata,
    output logic  pop,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  res,
    output logic  res_last
);

    logic out_valid_reg, out_valid_next;
    res_t out_reg, out_next;
    logic last_reg, last_next;
    logic pend_valid_reg, pend_valid_next;
    res_t pend_reg, pend_next;
    logic load;

    assign load = !out_valid_reg || out_ready;
    assign pop = load && !pend_valid_reg && nonempty;

    // output register, second result of a pair waits in pend
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        last_next = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_next = pend_reg;
        if (load)
        begin
            out_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next = pend_reg;
                last_next = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (nonempty)
            begin
                out_valid_next = 1'b1;
                out_next = rdata.r0;
                last_next = !rdata.two;
                pend_valid_next = rdata.two;
                pend_next = rdata.r1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        last_reg <= last_next;
        pend_reg <= pend_next;
    end

    assign out_valid = out_valid_reg;
    assign res = out_reg;
    assign res_last = last_reg;

    `STT_ASSERT(a_pend_behind_out, pend_valid_reg |-> out_valid_reg)
    `STT_ASSERT(a_pend_first_not_last, pend_valid_reg |-> !last_reg)
    `STT_ASSERT(a_pend_drains, (pend_valid_reg && out_ready) |=> (out_valid_reg && last_reg))

endmodule

/* hw/rtl/source_text_tokenizer_core.sv */
// Path: a byte's first token is written into the queue when the byte is taken, then
// loaded into the output register; a second token of the same byte waits in the pend register.
// Throughput: one byte per cycle while the queue is not full; the output register delivers
// one token per cycle while out_ready is high; the queue absorbs items with two tokens.
// Reset: rst_n asynchronous, active low; scanner returns to line 1, offset 0,
// queue and output are emptied.
`timescale 1ns / 1ps
module source_text_tokenizer_core
    import stt_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_mark,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [2:0]  error_code,
    output logic [15:0] line_number,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic        last
);

    logic  take, push, full, pop, nonempty;
    pair_t wentry, rentry;
    res_t  res;

    assign in_ready = !full;
    assign take = in_valid && in_ready;

    stt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .ch       (ch),
        .end_mark (end_mark),
        .push     (push),
        .entry    (wentry)
    );

    stt_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (wentry),
        .full     (full),
        .pop      (pop),
        .nonempty (nonempty),
        .rdata    (rentry)
    );

    stt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .nonempty  (nonempty),
        .rdata     (rentry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res),
        .res_last  (last)
    );

    assign token_kind = res.kind;
    assign error_code = res.err;
    assign line_number = res.line;
    assign start_offset = res.start;
    assign token_length = res.len;

endmodule
